[sv/asd_pkg.sv]
// Shared types and constants of the aligned sequence distance unit.
`default_nettype none
package asd_pkg;

	localparam logic [7:0]  GAP_CHAR = 8'h2D;
	localparam logic [16:0] ONE_Q16  = 17'h10000;
	localparam logic [15:0] OUT_MAX  = 16'hFFFF;

	typedef struct packed {
		logic [7:0] residue_a;
		logic [7:0] residue_b;
		logic       last_pair;
	} pair_t;

	typedef struct packed {
		logic [16:0] distance;
		logic [15:0] pair_count;
		logic [15:0] identical_count;
		logic [15:0] gap_count;
		logic        overflow;
	} result_t;

endpackage
`default_nettype wire

[sv/aligned_sequence_distance_unit.sv]
// Top level of the aligned sequence distance unit.
// The unit takes one aligned residue pair per clock and keeps saturating counts of pairs,
// identical pairs, identical non-gap pairs and gap pairs ('-' is the gap). The pair flagged
// last closes the alignment: its counts go into a two-entry queue and the front carries on
// with the next alignment at once. The back end turns each queued alignment into one result
// in one load, COUNT_BITS shift-add steps for numerator and denominator, one alignment
// step, 17 restoring division steps and one hand-over to the result register, which waits
// until the result slot is free. Pairs stream at one per clock while full is low; full
// rises while both queue entries are waiting. distance_mode is written through the cfg
// channel, is always ready, and is sampled with the last pair.
`default_nettype none
module aligned_sequence_distance_unit #(
	parameter int COUNT_BITS = 16,
	parameter int JOB_DEPTH  = 2
) (
	input  wire              clk,
	input  wire              arst_n,
	input  asd_pkg::pair_t   pair,
	input  wire              push,
	output logic             full,
	output asd_pkg::result_t result,
	output logic             empty,
	input  wire              pop,
	input  wire              cfg_valid,
	output logic             cfg_ready,
	input  wire              cfg_data
);

	localparam int JW = 4 * COUNT_BITS + 2;

	logic          job_full;
	logic          job_push;
	logic [JW-1:0] job_in;
	logic [JW-1:0] job_out;
	logic          job_empty;
	logic          job_pop;

	asd_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pair     (pair),
		.push     (push),
		.full     (full),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.job_full (job_full),
		.job_push (job_push),
		.job_data (job_in)
	);

	asd_queue #(
		.WIDTH(JW),
		.DEPTH(JOB_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_push),
		.wr_data(job_in),
		.full   (job_full),
		.rd_en  (job_pop),
		.rd_data(job_out),
		.empty  (job_empty)
	);

	asd_back #(
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_data (job_out),
		.job_empty(job_empty),
		.job_pop  (job_pop),
		.result   (result),
		.empty    (empty),
		.pop      (pop)
	);

`ifndef SYNTHESIS
	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.distance <= asd_pkg::ONE_Q16))
		else $error("distance above one");

	a_ident_le_len: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.identical_count <= result.pair_count))
		else $error("identical count above pair count");

	a_gap_le_len: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.gap_count <= result.pair_count))
		else $error("gap count above pair count");

	a_last_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && pair.last_pair) |=> !job_empty)
		else $error("last pair not queued");
`endif

endmodule
`default_nettype wire

[sv/asd_front.sv]
// Front end: takes residue pairs, keeps saturating counts, hands finished alignments to the queue.
`default_nettype none
module asd_front #(
	parameter int COUNT_BITS = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  asd_pkg::pair_t           pair,
	input  wire                      push,
	output logic                     full,
	input  wire                      cfg_valid,
	output logic                     cfg_ready,
	input  wire                      cfg_data,
	input  wire                      job_full,
	output logic                     job_push,
	output logic [4*COUNT_BITS+1:0]  job_data
);

	localparam int CB = COUNT_BITS;

	logic [CB-1:0] len_q, ident_q, nongap_q, gap_q;
	logic          ovf_q;
	logic          mode_q;

	logic [CB-1:0] len_n, ident_n, nongap_n, gap_n;
	logic          ovf_n;
	logic          accept;
	logic          same;
	logic          has_gap;

	function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v, input logic en);
		sat_inc = (en && (v != {CB{1'b1}})) ? v + 1'b1 : v;
	endfunction

	assign cfg_ready = 1'b1;
	assign full      = job_full;
	assign accept    = push & ~job_full;

	always_comb begin
		same     = (pair.residue_a == pair.residue_b);
		has_gap  = (pair.residue_a == asd_pkg::GAP_CHAR) ||
		           (pair.residue_b == asd_pkg::GAP_CHAR);
		ovf_n    = ovf_q | (len_q == {CB{1'b1}});
		len_n    = sat_inc(len_q, 1'b1);
		ident_n  = sat_inc(ident_q, same);
		gap_n    = sat_inc(gap_q, has_gap);
		nongap_n = sat_inc(nongap_q, same & ~has_gap);
	end

	assign job_push = accept & pair.last_pair;
	assign job_data = {mode_q, ovf_n, gap_n, nongap_n, ident_n, len_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			ident_q  <= '0;
			nongap_q <= '0;
			gap_q    <= '0;
			ovf_q    <= 1'b0;
			mode_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				mode_q <= cfg_data;
			end
			if (accept) begin
				if (pair.last_pair) begin
					len_q    <= '0;
					ident_q  <= '0;
					nongap_q <= '0;
					gap_q    <= '0;
					ovf_q    <= 1'b0;
				end else begin
					len_q    <= len_n;
					ident_q  <= ident_n;
					nongap_q <= nongap_n;
					gap_q    <= gap_n;
					ovf_q    <= ovf_n;
				end
			end
		end
	end

endmodule
`default_nettype wire

[sv/asd_queue.sv]
// Short shifting queue of finished alignment counts between front and back.
`default_nettype none
module asd_queue #(
	parameter int WIDTH = 66,
	parameter int DEPTH = 2
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              wr_en,
	input  wire  [WIDTH-1:0] wr_data,
	output logic             full,
	input  wire              rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [CNTW-1:0]  count_q;
	logic [CNTW-1:0]  wr_idx;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNTW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = slot_q[0];
	assign wr_idx  = do_rd ? count_q - 1'b1 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_q + CNTW'(do_wr) - CNTW'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (do_wr && (wr_idx == CNTW'(i))) begin
				slot_q[i] <= wr_data;
			end else if (do_rd && (i < DEPTH - 1)) begin
				slot_q[i] <= slot_q[(i < DEPTH - 1) ? i + 1 : i];
			end
		end
	end

endmodule
`default_nettype wire

[sv/asd_back.sv]
// Back end: shift-add products and restoring division that turn counts into a Q1.16 distance.
`default_nettype none
module asd_back #(
	parameter int COUNT_BITS = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire  [4*COUNT_BITS+1:0]  job_data,
	input  wire                      job_empty,
	output logic                     job_pop,
	output asd_pkg::result_t         result,
	output logic                     empty,
	input  wire                      pop
);

	localparam int CB       = COUNT_BITS;
	localparam int FW       = CB + 4;
	localparam int AW       = 2 * CB + 4;
	localparam int RW       = AW + 16;
	localparam int SW       = $clog2((CB > 17) ? CB : 17);
	localparam int CW       = (CB > 16) ? CB : 16;
	localparam int DIV_LAST = 16;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MUL   = 5'b00010,
		ST_ALIGN = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t           state_q;
	logic [SW-1:0]    step_q;
	logic             res_valid_q;
	asd_pkg::result_t res_q;

	logic [CB-1:0]    x_q, y_q;
	logic [AW-1:0]    fx_q, fy_q;
	logic [RW-1:0]    num_q, den_q;
	logic [16:0]      quo_q;
	logic             zero_q;
	logic [15:0]      pc_q, ic_q, gc_q;
	logic             ovf_q;

	logic [CB-1:0]    j_len, j_ident, j_nongap, j_gap;
	logic             j_ovf, j_mode;
	logic [CB-1:0]    g_clamp;
	logic [FW-1:0]    len_w, g_w, ten_l, nine_g, factor;
	logic             start;
	logic             slot_free;
	logic             ge;
	logic [16:0]      quo_clamp;
	logic [16:0]      dist_val;

	function automatic logic [15:0] clip16(input logic [CB-1:0] v);
		logic [CW-1:0] w;
		w = CW'(v);
		clip16 = (w > CW'(asd_pkg::OUT_MAX)) ? asd_pkg::OUT_MAX : w[15:0];
	endfunction

	always_comb begin
		j_len    = job_data[CB-1:0];
		j_ident  = job_data[2*CB-1:CB];
		j_nongap = job_data[3*CB-1:2*CB];
		j_gap    = job_data[4*CB-1:3*CB];
		j_ovf    = job_data[4*CB];
		j_mode   = job_data[4*CB+1];
		g_clamp  = (j_gap > j_len) ? j_len : j_gap;
		len_w    = FW'(j_len);
		g_w      = FW'(g_clamp);
		ten_l    = (len_w << 3) + (len_w << 1);
		nine_g   = (g_w << 3) + g_w;
		factor   = ten_l - nine_g;
	end

	assign start     = (state_q == ST_IDLE) && !job_empty;
	assign job_pop   = start;
	assign slot_free = !res_valid_q || pop;
	assign ge        = (num_q >= den_q);
	assign quo_clamp = (quo_q > asd_pkg::ONE_Q16) ? asd_pkg::ONE_Q16 : quo_q;
	assign dist_val  = zero_q ? asd_pkg::ONE_Q16 : asd_pkg::ONE_Q16 - quo_clamp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_MUL;
						step_q  <= '0;
					end
				end
				ST_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == SW'(CB - 1)) begin
						state_q <= ST_ALIGN;
					end
				end
				ST_ALIGN: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == SW'(DIV_LAST)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if ((state_q == ST_DONE) && slot_free) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					x_q    <= j_mode ? j_nongap : j_ident;
					y_q    <= j_len;
					fx_q   <= j_mode ? AW'(factor) : AW'(1);
					fy_q   <= j_mode ? AW'(ten_l) : AW'(1);
					num_q  <= '0;
					den_q  <= '0;
					zero_q <= (j_len == '0);
					pc_q   <= clip16(j_len);
					ic_q   <= clip16(j_mode ? j_nongap : j_ident);
					gc_q   <= clip16(j_gap);
					ovf_q  <= j_ovf | (CW'(j_len) > CW'(asd_pkg::OUT_MAX));
				end
			end
			ST_MUL: begin
				num_q <= num_q + (x_q[0] ? RW'(fx_q) : RW'(0));
				den_q <= den_q + (y_q[0] ? RW'(fy_q) : RW'(0));
				x_q   <= x_q >> 1;
				y_q   <= y_q >> 1;
				fx_q  <= fx_q << 1;
				fy_q  <= fy_q << 1;
			end
			ST_ALIGN: begin
				num_q <= num_q << 16;
				den_q <= den_q << 16;
				quo_q <= '0;
			end
			ST_DIV: begin
				if (ge) begin
					num_q <= num_q - den_q;
				end
				quo_q <= {quo_q[15:0], ge};
				den_q <= den_q >> 1;
			end
			ST_DONE: begin
				if (slot_free) begin
					res_q.distance        <= dist_val;
					res_q.pair_count      <= pc_q;
					res_q.identical_count <= ic_q;
					res_q.gap_count       <= gc_q;
					res_q.overflow        <= ovf_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign result = res_q;
	assign empty  = !res_valid_q;

endmodule
`default_nettype wire
